// ----- src/mls_pkg.sv -----
package mls_pkg;

    // Command codes of an input beat
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } mls_cmd_t;

    // Line level codes
    localparam logic [1:0] LEVEL_LOW      = 2'd0;
    localparam logic [1:0] LEVEL_HIGH     = 2'd1;
    localparam logic [1:0] LEVEL_RELEASED = 2'd2;

    // Frame layout
    localparam int unsigned START_HALF_BITS = 4;
    localparam int unsigned DATA_BITS       = 8;
    localparam int unsigned STEP_W          = 4;
    localparam int unsigned IDLE_W          = 4;
    localparam logic [IDLE_W-1:0] IDLE_INTERVAL_RST = 4'd4;

    // Start half-bits 1,0,0,1, indexed by step
    localparam logic [START_HALF_BITS-1:0] START_PATTERN = 4'b1001;

    typedef struct packed {
        mls_cmd_t    command;
        logic [7:0]  data_byte;
    } mls_in_t;

    typedef struct packed {
        logic        line_valid;
        logic [1:0]  line_level;
        logic        busy_res;
        logic        pending;
        logic        load_accepted;
    } mls_out_t;

endpackage

// ----- src/mls_core.sv -----
module mls_core
    import mls_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  mls_in_t           item,
    input  logic [IDLE_W-1:0] idle_interval,
    output mls_out_t          result
);

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_IDLE     = 2'd1,
        PH_START    = 2'd2,
        PH_DATA     = 2'd3
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                second_reg, second_next;
    logic [7:0]          shift_reg, shift_next;
    logic                waiting_reg, waiting_next;
    logic                sending_reg, sending_next;

    logic [STEP_W-1:0]   step_inc;
    logic [1:0]          level;
    logic                accepted;
    logic                msb;

    assign step_inc = step_reg + STEP_W'(1);
    assign msb      = shift_reg[7];

    // Work out the next state and the line level for this beat
    always_comb begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        second_next  = second_reg;
        shift_next   = shift_reg;
        waiting_next = waiting_reg;
        sending_next = sending_reg;
        level        = LEVEL_LOW;
        accepted     = 1'b0;
        if (item.command == CMD_TICK) begin
            unique case (phase_reg)
                PH_RELEASED: begin
                    step_next  = '0;
                    phase_next = PH_IDLE;
                    level      = LEVEL_RELEASED;
                end
                PH_IDLE: begin
                    level = LEVEL_LOW;
                    if ({1'b0, step_reg} + 5'd1 < {1'b0, idle_interval}) begin
                        step_next = step_inc;
                    end else if (waiting_reg) begin
                        step_next    = '0;
                        phase_next   = PH_START;
                        waiting_next = 1'b0;
                        sending_next = 1'b1;
                    end
                end
                PH_START: begin
                    level     = {1'b0, START_PATTERN[step_reg[1:0]]};
                    step_next = step_inc;
                    if (step_inc >= STEP_W'(START_HALF_BITS)) begin
                        phase_next = PH_DATA;
                        step_next  = '0;
                    end
                end
                PH_DATA: begin
                    level       = {1'b0, second_reg ? ~msb : msb};
                    second_next = ~second_reg;
                    if (second_reg) begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        step_next  = step_inc;
                    end
                    // end of frame once all data bits are out
                    if (second_reg && step_inc >= STEP_W'(DATA_BITS)) begin
                        phase_next   = PH_IDLE;
                        step_next    = '0;
                        sending_next = 1'b0;
                    end
                end
                default: begin
                    phase_next = PH_RELEASED;
                end
            endcase
        end else if (!sending_reg && !waiting_reg) begin
            // take the byte only when nothing is queued or on the wire
            shift_next   = item.data_byte;
            waiting_next = 1'b1;
            accepted     = 1'b1;
        end
    end

    assign result.line_valid    = (item.command == CMD_TICK);
    assign result.line_level    = level;
    assign result.busy_res      = sending_next;
    assign result.pending       = waiting_next;
    assign result.load_accepted = accepted;

    // Hold state; advance on each processed beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_RELEASED;
            step_reg    <= '0;
            second_reg  <= 1'b0;
            shift_reg   <= '0;
            waiting_reg <= 1'b0;
            sending_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            second_reg  <= second_next;
            shift_reg   <= shift_next;
            waiting_reg <= waiting_next;
            sending_reg <= sending_next;
        end
    end

    a_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(sending_reg && waiting_reg))
        else $error("byte pending while a frame is being sent");

    a_sending_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        sending_reg == (phase_reg == PH_START || phase_reg == PH_DATA))
        else $error("sending flag disagrees with phase");

    a_start_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_START) |-> (step_reg < STEP_W'(START_HALF_BITS)))
        else $error("start step out of range");

    a_data_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (step_reg < STEP_W'(DATA_BITS)))
        else $error("data step out of range");

endmodule

// ----- src/manchester_line_sender.sv -----
// Channel   Ports                          Beat
// input     s_valid s_ready s_data         mls_in_t: command, data_byte
// result    m_valid m_ready m_data         mls_out_t: line_valid .. load_accepted
// config    cfg_wr_en cfg_wr_data          idle_interval, 4 bits
//
// One result beat per input beat; one beat accepted per cycle when m_ready is high.
// Each beat passes an input register, then the state update feeding the
// result register.
// aresetn is synchronous, active low; the line starts released, idle_interval is 4.
// A stall on m_ready holds the result register and, while it holds a beat, the input.
module manchester_line_sender
    import mls_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mls_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mls_out_t          m_data,
    input  logic              cfg_wr_en,
    input  logic [IDLE_W-1:0] cfg_wr_data
);

    logic              in_valid_reg;
    mls_in_t           in_reg;
    logic              out_valid_reg;
    mls_out_t          out_reg;
    logic [IDLE_W-1:0] idle_interval_reg;
    logic              advance;
    mls_out_t          result;

    // Move the held input into the result register when it is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    mls_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .item          (in_reg),
        .idle_interval (idle_interval_reg),
        .result        (result)
    );

    // Hold control flags and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            idle_interval_reg <= IDLE_INTERVAL_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                idle_interval_reg <= cfg_wr_data;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
